/* hdl/rsqa_pkg.sv */
package rsqa_pkg;

  localparam int CHANNELS  = 2;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LVL_W     = 16;
  localparam int SUM_W     = 24;
  localparam int CNT_W     = 8;
  localparam int SPD_W     = 8;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int CFG_IDX_W = 3;

  localparam logic [LVL_W-1:0] WEAK_LEVEL = LVL_W'(34000);
  localparam logic [SPD_W-1:0] RAIN_SPEED = SPD_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DC_CANCEL_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_ADAPT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEFORE_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AFTER_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BEFORE_LIMIT_RN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AFTER_LIMIT_RN   = 3'd6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WEAK  = 2'd1,
    ST_SHIFT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV_GO,
    S_DIV_RUN,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DSEL_BEFORE = 2'd0,
    DSEL_AFTER  = 2'd1,
    DSEL_SIGNAL = 2'd2
  } dsel_t;

  typedef struct packed {
    logic [CNT_W-1:0] sample_count;
    logic [LVL_W-1:0] dc_cancel_threshold;
    logic             self_adapt_mode;
    logic [LVL_W-1:0] before_shift_limit;
    logic [LVL_W-1:0] after_shift_limit;
    logic [LVL_W-1:0] before_shift_limit_rain;
    logic [LVL_W-1:0] after_shift_limit_rain;
  } cfg_t;

endpackage

/* hdl/rsqa_cfg_regs.sv */
module rsqa_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsqa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsqa_pkg::LVL_W-1:0]     cfg_wdata,
  output rsqa_pkg::cfg_t                 cfg
);

  rsqa_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count            <= rsqa_pkg::CNT_W'(8);
      cfg_r.dc_cancel_threshold     <= rsqa_pkg::LVL_W'(1000);
      cfg_r.self_adapt_mode         <= 1'b0;
      cfg_r.before_shift_limit      <= rsqa_pkg::LVL_W'(500);
      cfg_r.after_shift_limit       <= rsqa_pkg::LVL_W'(500);
      cfg_r.before_shift_limit_rain <= rsqa_pkg::LVL_W'(500);
      cfg_r.after_shift_limit_rain  <= rsqa_pkg::LVL_W'(500);
    end else if (cfg_valid) begin
      case (cfg_index)
        rsqa_pkg::REG_SAMPLE_COUNT:    cfg_r.sample_count <= cfg_wdata[rsqa_pkg::CNT_W-1:0];
        rsqa_pkg::REG_DC_CANCEL_THR:   cfg_r.dc_cancel_threshold <= cfg_wdata;
        rsqa_pkg::REG_SELF_ADAPT:      cfg_r.self_adapt_mode <= cfg_wdata[0];
        rsqa_pkg::REG_BEFORE_LIMIT:    cfg_r.before_shift_limit <= cfg_wdata;
        rsqa_pkg::REG_AFTER_LIMIT:     cfg_r.after_shift_limit <= cfg_wdata;
        rsqa_pkg::REG_BEFORE_LIMIT_RN: cfg_r.before_shift_limit_rain <= cfg_wdata;
        rsqa_pkg::REG_AFTER_LIMIT_RN:  cfg_r.after_shift_limit_rain <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/rsqa_div.sv */
module rsqa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rsqa_pkg::SUM_W-1:0] dividend,
  input  logic [rsqa_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [rsqa_pkg::SUM_W-1:0] quotient
);

  localparam logic [rsqa_pkg::DIV_CNT_W-1:0] LAST = rsqa_pkg::DIV_CNT_W'(rsqa_pkg::SUM_W - 1);

  logic                           busy_r;
  logic                           done_r;
  logic [rsqa_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [rsqa_pkg::SUM_W-1:0]     quo_r;
  logic [rsqa_pkg::CNT_W-1:0]     rem_r;
  logic [rsqa_pkg::CNT_W-1:0]     dvs_r;
  logic [rsqa_pkg::CNT_W:0]       trial;
  logic                           fits;
  logic [rsqa_pkg::CNT_W:0]       rem_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[rsqa_pkg::SUM_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? (trial - {1'b0, dvs_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[rsqa_pkg::SUM_W-2:0], fits};
      rem_r <= rem_nxt[rsqa_pkg::CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hdl/rain_sample_qualifier_averager_top.sv */
// Rain sample qualifier/averager. One frame request is taken when in_valid is high and
// in_stall low; in_stall stays high while a frame is processed. A frame that does not
// close a batch (dropped, or added to the sums) returns to idle after evaluation; a
// weak-signal frame goes straight to result load. The frame that completes a batch
// runs three 24-bit by 8-bit divisions in turn through one shared bit-serial divider,
// then the ambient shift check and result load. A result waits in the output register,
// so the next frame is accepted while out_stall holds it; only a new result stalls
// behind a full output register.
module rain_sample_qualifier_averager_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_channel,
  input  logic [rsqa_pkg::LVL_W-1:0]     in_ambient_before,
  input  logic [rsqa_pkg::LVL_W-1:0]     in_signal_level,
  input  logic [rsqa_pkg::LVL_W-1:0]     in_ambient_after,
  input  logic [rsqa_pkg::SPD_W-1:0]     in_wiper_speed_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rsqa_pkg::LVL_W-1:0]     out_rain_value,
  output logic [1:0]                     out_status,
  output logic                           out_result_channel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsqa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsqa_pkg::LVL_W-1:0]     cfg_wdata
);

  rsqa_pkg::cfg_t   cfg;
  rsqa_pkg::state_t state_r, state_nxt;
  rsqa_pkg::dsel_t  dsel_r;

  logic                          chan_r;
  logic [rsqa_pkg::LVL_W-1:0]    amb_b_r, sig_r, amb_a_r;
  logic [rsqa_pkg::SPD_W-1:0]    speed_r;
  logic [rsqa_pkg::SUM_W-1:0]    sig_sum_r, bef_sum_r, aft_sum_r;
  logic [rsqa_pkg::CNT_W-1:0]    cnt_r;
  logic [rsqa_pkg::LVL_W-1:0]    saved_b_r [rsqa_pkg::CHANNELS];
  logic [rsqa_pkg::LVL_W-1:0]    saved_a_r [rsqa_pkg::CHANNELS];
  logic [rsqa_pkg::LVL_W-1:0]    avg_b_r, avg_a_r, avg_s_r;
  logic [rsqa_pkg::LVL_W-1:0]    res_value_r;
  rsqa_pkg::status_t             res_status_r;
  logic                          out_valid_r;
  logic [rsqa_pkg::LVL_W-1:0]    out_value_r;
  rsqa_pkg::status_t             out_status_r;
  logic                          out_chan_r;

  logic                          in_accept;
  logic                          out_free;
  logic                          do_eval, do_check, div_start, div_store, out_load;
  logic [rsqa_pkg::LVL_W-1:0]    amb_diff;
  logic                          counted, weak_sig, complete;
  logic [rsqa_pkg::CNT_W-1:0]    cnt_inc, need, divisor;
  logic [rsqa_pkg::SUM_W-1:0]    dividend, quotient;
  logic                          div_done;
  logic [rsqa_pkg::CH_IDX_W-1:0] slot;
  logic [rsqa_pkg::LVL_W-1:0]    d_b, d_a, lim_b, lim_a;
  logic                          shifted;

  rsqa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rsqa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign slot      = rsqa_pkg::CH_IDX_W'(chan_r);

  // frame qualification and batch bookkeeping
  always_comb begin
    amb_diff = (amb_b_r >= amb_a_r) ? (amb_b_r - amb_a_r) : (amb_a_r - amb_b_r);
    counted  = cfg.self_adapt_mode || (amb_diff < cfg.dc_cancel_threshold);
    weak_sig = sig_r <= rsqa_pkg::WEAK_LEVEL;
    cnt_inc  = cnt_r + 1'b1;
    need     = (cfg.sample_count == '0) ? rsqa_pkg::CNT_W'(1) : cfg.sample_count;
    complete = (cnt_inc == '0) || (cnt_inc >= need);
    divisor  = (cnt_r == '0) ? rsqa_pkg::CNT_W'(1) : cnt_r;
  end

  always_comb begin
    case (dsel_r)
      rsqa_pkg::DSEL_BEFORE: dividend = bef_sum_r;
      rsqa_pkg::DSEL_AFTER:  dividend = aft_sum_r;
      rsqa_pkg::DSEL_SIGNAL: dividend = sig_sum_r;
      default:               dividend = sig_sum_r;
    endcase
  end

  always_comb begin
    if (speed_r > rsqa_pkg::RAIN_SPEED) begin
      lim_b = cfg.before_shift_limit_rain;
      lim_a = cfg.after_shift_limit_rain;
    end else begin
      lim_b = cfg.before_shift_limit;
      lim_a = cfg.after_shift_limit;
    end
    d_b = (saved_b_r[slot] >= avg_b_r) ? (saved_b_r[slot] - avg_b_r)
                                       : (avg_b_r - saved_b_r[slot]);
    d_a = (saved_a_r[slot] >= avg_a_r) ? (saved_a_r[slot] - avg_a_r)
                                       : (avg_a_r - saved_a_r[slot]);
    shifted = (d_b > lim_b) || (d_a > lim_a);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsqa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rsqa_pkg::S_EVAL;
      end
      rsqa_pkg::S_EVAL: begin
        if (!counted)      state_nxt = rsqa_pkg::S_IDLE;
        else if (weak_sig) state_nxt = rsqa_pkg::S_EMIT;
        else if (complete) state_nxt = rsqa_pkg::S_DIV_GO;
        else               state_nxt = rsqa_pkg::S_IDLE;
      end
      rsqa_pkg::S_DIV_GO: state_nxt = rsqa_pkg::S_DIV_RUN;
      rsqa_pkg::S_DIV_RUN: begin
        if (div_done) begin
          if (dsel_r == rsqa_pkg::DSEL_SIGNAL) state_nxt = rsqa_pkg::S_CHECK;
          else                                 state_nxt = rsqa_pkg::S_DIV_GO;
        end
      end
      rsqa_pkg::S_CHECK: state_nxt = rsqa_pkg::S_EMIT;
      rsqa_pkg::S_EMIT: begin
        if (out_free) state_nxt = rsqa_pkg::S_IDLE;
      end
      default: state_nxt = rsqa_pkg::S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    in_stall  = 1'b1;
    do_eval   = 1'b0;
    div_start = 1'b0;
    div_store = 1'b0;
    do_check  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      rsqa_pkg::S_IDLE:    in_stall  = 1'b0;
      rsqa_pkg::S_EVAL:    do_eval   = 1'b1;
      rsqa_pkg::S_DIV_GO:  div_start = 1'b1;
      rsqa_pkg::S_DIV_RUN: div_store = div_done;
      rsqa_pkg::S_CHECK:   do_check  = 1'b1;
      rsqa_pkg::S_EMIT:    out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsqa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      chan_r  <= in_channel;
      amb_b_r <= in_ambient_before;
      sig_r   <= in_signal_level;
      amb_a_r <= in_ambient_after;
      speed_r <= in_wiper_speed_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_sum_r <= '0;
      bef_sum_r <= '0;
      aft_sum_r <= '0;
      cnt_r     <= '0;
      for (int k = 0; k < rsqa_pkg::CHANNELS; k++) begin
        saved_b_r[k] <= '0;
        saved_a_r[k] <= '0;
      end
    end else if (do_eval && counted) begin
      if (weak_sig) begin
        sig_sum_r <= '0;
        bef_sum_r <= '0;
        aft_sum_r <= '0;
        cnt_r     <= '0;
      end else begin
        sig_sum_r <= sig_sum_r + rsqa_pkg::SUM_W'(sig_r);
        bef_sum_r <= bef_sum_r + rsqa_pkg::SUM_W'(amb_b_r);
        aft_sum_r <= aft_sum_r + rsqa_pkg::SUM_W'(amb_a_r);
        cnt_r     <= cnt_inc;
      end
    end else if (do_check) begin
      sig_sum_r       <= '0;
      bef_sum_r       <= '0;
      aft_sum_r       <= '0;
      cnt_r           <= '0;
      saved_b_r[slot] <= avg_b_r;
      saved_a_r[slot] <= avg_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsel_r <= rsqa_pkg::DSEL_BEFORE;
    end else if (do_eval) begin
      dsel_r <= rsqa_pkg::DSEL_BEFORE;
    end else if (div_store) begin
      case (dsel_r)
        rsqa_pkg::DSEL_BEFORE: dsel_r <= rsqa_pkg::DSEL_AFTER;
        rsqa_pkg::DSEL_AFTER:  dsel_r <= rsqa_pkg::DSEL_SIGNAL;
        default:               dsel_r <= rsqa_pkg::DSEL_BEFORE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_store) begin
      case (dsel_r)
        rsqa_pkg::DSEL_BEFORE: avg_b_r <= quotient[rsqa_pkg::LVL_W-1:0];
        rsqa_pkg::DSEL_AFTER:  avg_a_r <= quotient[rsqa_pkg::LVL_W-1:0];
        default:               avg_s_r <= quotient[rsqa_pkg::LVL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_eval) begin
      res_value_r  <= '0;
      res_status_r <= rsqa_pkg::ST_WEAK;
    end else if (do_check) begin
      res_value_r  <= shifted ? '0 : avg_s_r;
      res_status_r <= shifted ? rsqa_pkg::ST_SHIFT : rsqa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_chan_r   <= chan_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rain_value     = out_value_r;
  assign out_status         = out_status_r;
  assign out_result_channel = out_chan_r;

endmodule
